FILE: rtl/core/ismx_pkg.sv
package ismx_pkg;
    localparam int STACK_DEPTH = 32;
    localparam int MEM_WORDS = 256;
    localparam int DATA_WIDTH = 64;
    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int MA_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

    typedef enum logic [4:0] {
        ACT_PUSH = 5'd0, ACT_POP = 5'd1, ACT_TOP = 5'd2, ACT_LOAD = 5'd3,
        ACT_STORE = 5'd4, ACT_ABS = 5'd5, ACT_ADD = 5'd6, ACT_SUB = 5'd7,
        ACT_MUL = 5'd8, ACT_DIV = 5'd9, ACT_MOD = 5'd10, ACT_INC = 5'd11,
        ACT_DEC = 5'd12, ACT_NEG = 5'd13, ACT_ANALYZE = 5'd14, ACT_CMP = 5'd15,
        ACT_SWAP = 5'd16, ACT_DUP = 5'd17
    } t_action;

    localparam logic [2:0] ERR_OK = 3'd0;
    localparam logic [2:0] ERR_UNDER = 3'd1;
    localparam logic [2:0] ERR_OVER = 3'd2;
    localparam logic [2:0] ERR_DIV0 = 3'd3;
    localparam logic [2:0] ERR_ACTION = 3'd4;

    typedef struct packed {
        logic [4:0]  action;
        logic [63:0] immediate;
        logic [7:0]  mem_address;
        logic        no_flag_change;
    } t_in;

    typedef struct packed {
        logic        analyze_valid;
        logic [63:0] analyze_value;
        logic [2:0]  error_code;
        logic [5:0]  stack_depth;
    } t_out;
endpackage

FILE: rtl/core/ismx_if.sv
interface ismx_in_if import ismx_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ismx_out_if import ismx_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/integer_stack_machine_executor_unit.sv
// steps from input transfer to result: read top, read second, execute, write back;
// mul adds a partial-product pass, and div and mod run in the shift-subtract
// divider; an error found at transfer skips these steps and goes straight to the result
// one instruction at a time: a new transfer is taken only back in idle, and a waiting
// result holds the next transfer but not the stack write, which is done before it
// reset: stack pointer cleared at once; then a pass zeroes all MEM_WORDS data memory words
module integer_stack_machine_executor_unit import ismx_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    ismx_in_if.sink    i_in,
    ismx_out_if.source o_out
);
    localparam int DW = DATA_WIDTH;
    localparam int HW = DW / 2;
    localparam int MC_W = $clog2(MEM_WORDS + 1);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EXEC, S_DIV, S_MUL, S_DONE
    } t_state;

    t_state r_state;
    t_in r_in;
    logic [SP_W-1:0] r_sp;
    logic [MC_W-1:0] r_clr;
    logic [DW-1:0] r_a, r_b;
    logic [2:0] r_err;
    t_out r_outq;
    logic [SP_W-1:0] r_spq;
    logic [1:0] r_mcnt;
    logic [DW-1:0] r_acc;

    logic s_we, m_we;
    logic [SA_W-1:0] s_wa, s_ra;
    logic [DW-1:0] s_wd, s_rd, m_wd, m_rd;
    logic [MA_W-1:0] m_wa, m_ra;
    logic d_start, d_done;
    logic [DW-1:0] d_quo, d_rem;
    logic w_slot;

    ismx_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_wa), .i_wdata(s_wd),
        .i_raddr(s_ra), .o_rdata(s_rd));
    ismx_ram #(.WIDTH(DW), .DEPTH(MEM_WORDS)) u_dmem (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_wa), .i_wdata(m_wd),
        .i_raddr(m_ra), .o_rdata(m_rd));

    logic [DW-1:0] w_ma, w_mb;
    assign w_ma = r_a[DW-1] ? -r_a : r_a;
    assign w_mb = r_b[DW-1] ? -r_b : r_b;
    ismx_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_num(w_mb), .i_den(w_ma), .o_done(d_done), .o_quo(d_quo), .o_rem(d_rem));

    // low half of the product from three half-width partial products
    logic [HW-1:0] w_mx, w_my;
    logic [DW-1:0] w_mp;
    always_comb begin
        case (r_mcnt)
            2'd0: begin w_mx = r_a[HW-1:0]; w_my = r_b[HW-1:0]; end
            2'd1: begin w_mx = r_a[HW-1:0]; w_my = r_b[DW-1:HW]; end
            default: begin w_mx = r_a[DW-1:HW]; w_my = r_b[HW-1:0]; end
        endcase
    end
    assign w_mp = DW'(w_mx) * DW'(w_my);

    logic [1:0] w_need;
    logic w_grow, w_keep, w_bad;
    always_comb begin
        w_need = 2'd0; w_grow = 1'b0; w_bad = 1'b0;
        case (i_in.data.action)
            ACT_PUSH, ACT_LOAD: w_grow = 1'b1;
            ACT_POP, ACT_STORE, ACT_TOP, ACT_ABS, ACT_INC, ACT_DEC, ACT_NEG,
            ACT_ANALYZE: w_need = 2'd1;
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_CMP, ACT_SWAP:
                w_need = 2'd2;
            ACT_DUP: begin w_need = 2'd1; w_grow = 1'b1; end
            default: w_bad = 1'b1;
        endcase
        w_keep = (w_need != 2'd0) && i_in.data.action != ACT_POP
            && i_in.data.action != ACT_STORE && i_in.data.action != ACT_CMP;
    end

    logic [2:0] w_err;
    logic [SP_W:0] w_after;
    assign w_after = {1'b0, r_sp} - (SP_W+1)'(w_need) + (SP_W+1)'(w_keep)
        + (SP_W+1)'(w_grow);
    always_comb begin
        if (w_bad) w_err = ERR_ACTION;
        else if (r_sp < SP_W'(w_need)) w_err = ERR_UNDER;
        else if (w_after > (SP_W+1)'(STACK_DEPTH)) w_err = ERR_OVER;
        else w_err = ERR_OK;
    end

    logic [SA_W-1:0] w_top, w_sec;
    assign w_top = SA_W'(r_sp - 1'b1);
    assign w_sec = SA_W'(r_sp - 2'd2);
    assign s_ra = (r_state == S_RD1) ? w_sec : w_top;
    assign m_ra = MA_W'(r_in.mem_address % MEM_WORDS);

    logic [DW-1:0] w_res;
    always_comb begin
        case (t_action'(r_in.action))
            ACT_PUSH: w_res = r_in.immediate[DW-1:0];
            ACT_LOAD: w_res = m_rd;
            ACT_ABS: w_res = w_ma;
            ACT_ADD: w_res = r_b + r_a;
            ACT_SUB, ACT_CMP: w_res = r_b - r_a;
            ACT_MUL: w_res = r_acc;
            ACT_INC: w_res = r_a + 1'b1;
            ACT_DEC: w_res = r_a - 1'b1;
            ACT_NEG: w_res = -r_a;
            ACT_SWAP: w_res = r_b;
            default: w_res = r_a;
        endcase
    end

    t_out n_out;
    logic [DW-1:0] n_w;
    always_comb begin
        n_w = w_res;
        if (r_state == S_DIV) begin
            if (t_action'(r_in.action) == ACT_DIV)
                n_w = (r_b[DW-1] != r_a[DW-1]) ? -d_quo : d_quo;
            else
                n_w = r_b[DW-1] ? -d_rem : d_rem;
        end
    end

    logic [SP_W-1:0] n_sp;
    always_comb begin
        case (t_action'(r_in.action))
            ACT_PUSH, ACT_LOAD, ACT_DUP: n_sp = r_sp + 1'b1;
            ACT_POP, ACT_STORE, ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD,
            ACT_CMP: n_sp = r_sp - 1'b1;
            default: n_sp = r_sp;
        endcase
    end

    logic w_fin;
    assign w_fin = (r_state == S_EXEC && r_in.action != ACT_DIV && r_in.action != ACT_MOD
            && r_in.action != ACT_MUL)
        || (r_state == S_DIV && d_done) || (r_state == S_MUL && r_mcnt == 2'd3);

    always_comb begin
        s_we = 1'b0; s_wa = w_top; s_wd = n_w;
        if (w_fin) begin
            case (t_action'(r_in.action))
                ACT_PUSH, ACT_LOAD, ACT_DUP: begin s_we = 1'b1; s_wa = SA_W'(r_sp); end
                ACT_ABS, ACT_INC, ACT_DEC, ACT_NEG: s_we = 1'b1;
                ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
                    s_we = 1'b1; s_wa = w_sec;
                end
                default: ;
            endcase
        end
        if (r_state == S_EXEC && t_action'(r_in.action) == ACT_SWAP) begin
            s_we = 1'b1; s_wa = w_sec; s_wd = r_a;
        end
        if (r_state == S_DONE && r_err == ERR_OK && t_action'(r_in.action) == ACT_SWAP) begin
            s_we = 1'b1; s_wa = w_top; s_wd = r_b;
        end
    end

    always_comb begin
        m_we = 1'b0; m_wa = MA_W'(r_in.mem_address % MEM_WORDS); m_wd = r_a;
        if (r_state == S_CLEAR) begin
            m_we = 1'b1; m_wa = MA_W'(r_clr); m_wd = '0;
        end else if (w_fin && t_action'(r_in.action) == ACT_STORE) begin
            m_we = 1'b1;
        end
    end

    assign d_start = r_state == S_EXEC
        && (r_in.action == ACT_DIV || r_in.action == ACT_MOD) && r_a != '0;
    assign w_slot = !o_out.valid || o_out.ready;
    assign i_in.ready = r_state == S_IDLE;

    always_comb begin
        n_out.analyze_valid = !r_in.no_flag_change
            || r_in.action == ACT_ANALYZE || r_in.action == ACT_CMP;
        n_out.analyze_value = 64'($signed(n_w));
        n_out.error_code = ERR_OK;
        n_out.stack_depth = 6'(n_sp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_sp <= '0;
            r_clr <= '0;
            o_out.valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_slot) o_out.valid <= 1'b1;
            else if (o_out.valid && o_out.ready) o_out.valid <= 1'b0;
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == MC_W'(MEM_WORDS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: if (i_in.valid && i_in.ready) begin
                    r_in <= i_in.data;
                    r_err <= w_err;
                    if (w_err != ERR_OK) begin
                        r_outq <= '{1'b0, 64'd0, w_err, 6'(r_sp)};
                        r_spq <= r_sp;
                        r_state <= S_DONE;
                    end else r_state <= S_RD1;
                end
                S_RD1: begin
                    r_a <= s_rd;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_b <= s_rd;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_mcnt <= '0;
                    if (r_in.action == ACT_DIV || r_in.action == ACT_MOD) begin
                        if (r_a == '0) begin
                            r_outq <= '{1'b0, 64'd0, ERR_DIV0, 6'(r_sp)};
                            r_spq <= r_sp;
                            r_state <= S_DONE;
                        end else r_state <= S_DIV;
                    end else if (r_in.action == ACT_MUL) r_state <= S_MUL;
                    else r_state <= S_DONE;
                end
                S_DIV: if (d_done) r_state <= S_DONE;
                S_MUL: begin
                    if (r_mcnt == 2'd3) r_state <= S_DONE;
                    else begin
                        if (r_mcnt == 2'd0) r_acc <= w_mp;
                        else r_acc <= r_acc + {w_mp[HW-1:0], {HW{1'b0}}};
                        r_mcnt <= r_mcnt + 1'b1;
                    end
                end
                S_DONE: if (w_slot) begin
                    o_out.data <= r_outq;
                    r_sp <= r_spq;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            if (w_fin) begin
                r_outq <= n_out;
                r_spq <= n_sp;
            end
        end
    end
endmodule

FILE: rtl/core/ismx_ram.sv
module ismx_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: rtl/core/ismx_div.sv
module ismx_div import ismx_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_num,
    input  logic [DATA_WIDTH-1:0] i_den,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_quo,
    output logic [DATA_WIDTH-1:0] o_rem
);
    localparam int CW = $clog2(DATA_WIDTH + 1);
    logic [CW-1:0] r_cnt;
    logic [DATA_WIDTH-1:0] r_q, r_r, r_d;
    logic [DATA_WIDTH:0] w_sh, w_diff;

    assign w_sh = {r_r, r_q[DATA_WIDTH-1]};
    assign w_diff = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DATA_WIDTH);
                r_q <= i_num;
                r_r <= '0;
                r_d <= i_den;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (!w_diff[DATA_WIDTH]) begin
                    r_r <= w_diff[DATA_WIDTH-1:0];
                    r_q <= {r_q[DATA_WIDTH-2:0], 1'b1};
                end else begin
                    r_r <= w_sh[DATA_WIDTH-1:0];
                    r_q <= {r_q[DATA_WIDTH-2:0], 1'b0};
                end
                if (r_cnt == CW'(1)) o_done <= 1'b1;
            end
        end
    end
    assign o_quo = r_q;
    assign o_rem = r_r;
endmodule

FILE: tb/sv/integer_stack_machine_executor_unit_test.sv
`timescale 1ns / 1ps
module integer_stack_machine_executor_unit_test;
    import ismx_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ismx_in_if  in_ch ();
    ismx_out_if out_ch ();

    integer_stack_machine_executor_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POS = 64'h7fff_ffff_ffff_ffff;

    // predictor state
    logic [63:0] pred_stack [STACK_DEPTH];
    int unsigned pred_sp;
    logic [63:0] pred_mem [MEM_WORDS];
    t_out        expected_q [$];

    int          fail_count = 0;
    longint      cycle_count = 0;
    int          send_idle_pct = 21;
    int          recv_idle_pct = 67;
    bit          hold_recv = 1'b0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    function automatic logic [63:0] neg64(input logic [63:0] v);
        return 64'd0 - v;
    endfunction

    function automatic t_out execute_instr(input t_in item);
        t_out        r;
        t_action     act;
        int unsigned need, grow, keep;
        logic [2:0]  err;
        logic [63:0] a, b, w, mb, ma;
        logic        flag;
        act = t_action'(item.action);
        need = 0; grow = 0; err = ERR_OK; a = '0; b = '0; w = '0;
        flag = !item.no_flag_change;
        case (act)
            ACT_PUSH, ACT_LOAD: grow = 1;
            ACT_POP, ACT_STORE, ACT_TOP, ACT_ANALYZE, ACT_ABS, ACT_INC, ACT_DEC,
            ACT_NEG: need = 1;
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_CMP, ACT_SWAP: need = 2;
            ACT_DUP: begin need = 1; grow = 1; end
            default: err = ERR_ACTION;
        endcase
        keep = (need > 0 && act != ACT_POP && act != ACT_STORE && act != ACT_CMP);
        if (err == ERR_OK && pred_sp < need) err = ERR_UNDER;
        else if (err == ERR_OK && pred_sp - need + keep + grow > STACK_DEPTH)
            err = ERR_OVER;
        if (err == ERR_OK && need >= 1) a = pred_stack[pred_sp - 1];
        if (err == ERR_OK && need >= 2) b = pred_stack[pred_sp - 2];
        if (err == ERR_OK && (act == ACT_DIV || act == ACT_MOD) && a == 0)
            err = ERR_DIV0;
        if (err != ERR_OK) begin
            r.analyze_valid = 1'b0; r.analyze_value = '0; r.error_code = err;
            r.stack_depth = pred_sp[5:0];
            return r;
        end
        case (act)
            ACT_PUSH: begin w = item.immediate; pred_stack[pred_sp] = w; pred_sp++; end
            ACT_POP: begin w = a; pred_sp--; end
            ACT_TOP: w = a;
            ACT_LOAD: begin
                w = pred_mem[item.mem_address % MEM_WORDS];
                pred_stack[pred_sp] = w; pred_sp++;
            end
            ACT_STORE: begin w = a; pred_mem[item.mem_address % MEM_WORDS] = w; pred_sp--; end
            ACT_ABS: begin w = a[63] ? neg64(a) : a; pred_stack[pred_sp - 1] = w; end
            ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD: begin
                mb = b[63] ? neg64(b) : b;
                ma = a[63] ? neg64(a) : a;
                case (act)
                    ACT_ADD: w = b + a;
                    ACT_SUB: w = b - a;
                    ACT_MUL: w = b * a;
                    ACT_DIV: begin w = mb / ma; if (b[63] != a[63]) w = neg64(w); end
                    default: begin w = mb % ma; if (b[63]) w = neg64(w); end
                endcase
                pred_sp--; pred_stack[pred_sp - 1] = w;
            end
            ACT_INC: begin w = a + 1; pred_stack[pred_sp - 1] = w; end
            ACT_DEC: begin w = a - 1; pred_stack[pred_sp - 1] = w; end
            ACT_NEG: begin w = neg64(a); pred_stack[pred_sp - 1] = w; end
            ACT_ANALYZE: begin w = a; flag = 1'b1; end
            ACT_CMP: begin w = b - a; pred_sp--; flag = 1'b1; end
            ACT_SWAP: begin
                pred_stack[pred_sp - 2] = a; pred_stack[pred_sp - 1] = b; w = b;
            end
            default: begin w = a; pred_stack[pred_sp] = a; pred_sp++; end
        endcase
        r.analyze_valid = flag; r.analyze_value = w; r.error_code = ERR_OK;
        r.stack_depth = pred_sp[5:0];
        return r;
    endfunction

    // directed rows: expected value checked where chk is set
    typedef struct {
        t_action     act;
        logic [63:0] imm;
        logic [7:0]  addr;
        logic        nfc;
        bit          chk;
        t_out        want;
    } t_row;

    t_row rows [$];

    function automatic t_out mk(input logic v, input logic [63:0] val,
                                input logic [2:0] e, input logic [5:0] d);
        t_out r;
        r.analyze_valid = v; r.analyze_value = val; r.error_code = e; r.stack_depth = d;
        return r;
    endfunction

    function automatic t_row row(input t_action a, input logic [63:0] imm,
                                 input logic [7:0] addr, input logic nfc,
                                 input bit chk = 0, input t_out want = '0);
        t_row r;
        r.act = a; r.imm = imm; r.addr = addr; r.nfc = nfc; r.chk = chk; r.want = want;
        return r;
    endfunction

    task automatic send_item(input t_in item, input t_row r);
        t_out exp_res;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        exp_res = execute_instr(item);
        if (r.chk && exp_res != r.want) begin
            report_mismatch("directed row", {58'd0, r.act, 1'b0}, '0);
        end
        expected_q.push_back(exp_res);
        in_ch.data <= item;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    function automatic t_in rand_item(input int unsigned mode);
        t_in it;
        int unsigned pick;
        it.immediate = {$urandom, $urandom};
        pick = $urandom_range(9);
        if (pick == 0) it.immediate = MOST_NEG;
        else if (pick == 1) it.immediate = MOST_POS;
        else if (pick == 2) it.immediate = 64'(int'($urandom_range(6)) - 3);
        it.mem_address = (mode == 0) ? 8'($urandom_range(7)) : 8'($urandom);
        it.no_flag_change = 1'($urandom_range(1));
        if ($urandom_range(29) == 0) it.action = 5'($urandom_range(31, 18));
        else if (pred_sp < 3 && $urandom_range(2) != 0)
            it.action = $urandom_range(1) ? ACT_PUSH : ACT_LOAD;
        else if (pred_sp > 28 && $urandom_range(2) != 0)
            it.action = $urandom_range(1) ? ACT_POP : ACT_STORE;
        else it.action = 5'($urandom_range(17));
        return it;
    endfunction

    // receiver
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_recv) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_out got, want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", got.analyze_value, '0);
            end else begin
                want = expected_q.pop_front();
                if (got.analyze_valid !== want.analyze_valid)
                    report_mismatch("analyze_valid", 64'(got.analyze_valid),
                                    64'(want.analyze_valid));
                if (got.analyze_value !== want.analyze_value)
                    report_mismatch("analyze_value", got.analyze_value, want.analyze_value);
                if (got.error_code !== want.error_code)
                    report_mismatch("error_code", 64'(got.error_code), 64'(want.error_code));
                if (got.stack_depth !== want.stack_depth)
                    report_mismatch("stack_depth", 64'(got.stack_depth), 64'(want.stack_depth));
            end
        end
        if (cycle_count > 1500000) begin
            $display("timeout at cycle %0d", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        t_in   item;
        t_row  r;
        t_row  none_row;
        int    n;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        pred_sp = 0;
        foreach (pred_stack[k]) pred_stack[k] = '0;
        foreach (pred_mem[k]) pred_mem[k] = '0;
        none_row = row(ACT_PUSH, 0, 0, 0);

        rows.push_back(row(ACT_POP, 0, 0, 0, 1, mk(0, 0, ERR_UNDER, 0)));
        rows.push_back(row(ACT_LOAD, 0, 8'd255, 0, 1, mk(1, 0, ERR_OK, 1)));
        rows.push_back(row(ACT_ADD, 0, 0, 0, 1, mk(0, 0, ERR_UNDER, 1)));
        rows.push_back(row(t_action'(5'd31), 0, 0, 0, 1, mk(0, 0, ERR_ACTION, 1)));
        rows.push_back(row(ACT_DIV, 0, 0, 0, 1, mk(0, 0, ERR_UNDER, 1)));
        rows.push_back(row(ACT_PUSH, MOST_NEG, 0, 1, 1, mk(0, MOST_NEG, ERR_OK, 2)));
        rows.push_back(row(ACT_PUSH, 0, 0, 0));
        rows.push_back(row(ACT_DIV, 0, 0, 0, 1, mk(0, 0, ERR_DIV0, 3)));
        rows.push_back(row(ACT_POP, 0, 0, 0));
        rows.push_back(row(ACT_ABS, 0, 0, 0, 1, mk(1, MOST_NEG, ERR_OK, 2)));
        rows.push_back(row(ACT_NEG, 0, 0, 0, 1, mk(1, MOST_NEG, ERR_OK, 2)));
        rows.push_back(row(ACT_DUP, 0, 0, 1));
        rows.push_back(row(ACT_PUSH, '1, 0, 0, 1, mk(1, '1, ERR_OK, 4)));
        rows.push_back(row(ACT_DIV, 0, 0, 0, 1, mk(1, MOST_NEG, ERR_OK, 3)));
        rows.push_back(row(ACT_PUSH, '1, 0, 0));
        rows.push_back(row(ACT_MOD, 0, 0, 0, 1, mk(1, 0, ERR_OK, 3)));
        rows.push_back(row(ACT_PUSH, MOST_POS, 0, 0));
        rows.push_back(row(ACT_SWAP, 0, 0, 0));
        rows.push_back(row(ACT_SUB, 0, 0, 0));
        rows.push_back(row(ACT_MUL, 0, 0, 0));
        rows.push_back(row(ACT_INC, 0, 0, 1));
        rows.push_back(row(ACT_DEC, 0, 0, 0));
        rows.push_back(row(ACT_TOP, 0, 0, 0));
        rows.push_back(row(ACT_ANALYZE, 0, 0, 1));
        rows.push_back(row(ACT_CMP, 0, 0, 1));
        rows.push_back(row(ACT_STORE, 0, 8'd7, 0));
        rows.push_back(row(ACT_LOAD, 0, 8'd7, 0));

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) begin
            r = rows[k];
            item.action = r.act; item.immediate = r.imm;
            item.mem_address = r.addr; item.no_flag_change = r.nfc;
            send_item(item, r);
        end

        // push until the stack is full and beyond, holding the receiver off at first, then drain
        fork
            begin
                hold_recv = 1'b1;
                repeat (400) @(negedge i_clk);
                hold_recv = 1'b0;
            end
        join_none
        for (n = 0; n < 40; n++) begin
            item = rand_item(0);
            item.action = ACT_PUSH;
            send_item(item, none_row);
        end
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);

        for (n = 0; n < 1900; n++) begin
            if (n == 630) begin send_idle_pct = 67; recv_idle_pct = 21; end
            if (n == 1260) begin send_idle_pct = 0; recv_idle_pct = 0; end
            item = rand_item(n % 3);
            send_item(item, none_row);
        end
        in_ch.valid <= 1'b0;

        n = 0;
        while (expected_q.size() != 0 && n < 200000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (100) @(negedge i_clk);
        if (fail_count == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
